// File: rtl/qvr_pkg.sv
// Shared widths and types for the quaternion vector rotation unit.
package qvr_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam int unsigned PROD_W  = 2 * FIELD_W;      // q * v product
    localparam int unsigned P_W     = PROD_W + 2;       // sum of three products
    localparam int unsigned NORM_W  = PROD_W + 1;       // sum of four squares
    localparam int unsigned PQ_W    = P_W + FIELD_W;    // p * q product
    localparam int unsigned NUM_W   = PQ_W + 2;         // sum of four products
    localparam int unsigned REM_W   = NUM_W;            // rounded magnitude
    localparam int unsigned QUO_W   = FIELD_W;          // quotient bits kept
    localparam int unsigned LANES   = 3;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic signed [P_W-1:0]     p_t;
    typedef logic signed [PQ_W-1:0]    pq_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic        [REM_W-1:0]   rem_t;
    typedef logic        [NORM_W-1:0]  norm_t;
    typedef logic        [QUO_W-1:0]   quo_t;

    localparam field_t SAT_MAX = field_t'(16'sh7FFF);
    localparam field_t SAT_MIN = field_t'(16'sh8000);

endpackage

// File: rtl/qvr_in_if.sv
// Input channel: vector and quaternion beat.
interface qvr_in_if
    import qvr_pkg::*;
();
    logic   valid;
    logic   ready;
    field_t vec_x;
    field_t vec_y;
    field_t vec_z;
    field_t quat_w;
    field_t quat_x;
    field_t quat_y;
    field_t quat_z;

    modport source (output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                    output ready);
endinterface

// File: rtl/qvr_out_if.sv
// Output channel: rotated vector beat.
interface qvr_out_if
    import qvr_pkg::*;
();
    logic   valid;
    logic   ready;
    field_t rot_x;
    field_t rot_y;
    field_t rot_z;
    logic   zero_norm;
    logic   saturated;

    modport source (output valid, rot_x, rot_y, rot_z, zero_norm, saturated, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, zero_norm, saturated, output ready);
endinterface

// File: rtl/quaternion_vector_rotate_unit.sv
// Quaternion vector rotation r = q * (0,v) * conj(q) / |q|^2, fully pipelined.
// Takes one beat per clock while the output is not stalled, and is built of five stages of
// multiply and add, then a restoring divider by |q|^2 with one quotient bit
// per stage (a range check plus 16 bit stages), then the output register.
// The whole pipeline moves together and holds while the output beat is not
// taken. The quotient is rounded to nearest, ties away from zero, and clamped
// to Q8.8; a zero quaternion gives zero_norm and a zero vector.
module quaternion_vector_rotate_unit
    import qvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qvr_in_if.sink    vec_in,
    qvr_out_if.source rot_out
);

    localparam int unsigned DIV_ST = QUO_W + 1;

    logic adv;

    // stage 1: products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] qv1_reg [0:11];
    logic signed [PROD_W-1:0] sq1_reg [0:3];
    field_t                   q1_reg  [0:3];
    // stage 2: p = q * (0,v), |q|^2
    logic  v2_reg;
    p_t    p2_reg [0:3];
    norm_t nrm2_reg;
    field_t q2_reg [0:3];
    // stage 3: p * conj(q) products
    logic  v3_reg;
    pq_t   pq3_reg [0:11];
    norm_t nrm3_reg;
    // stage 4: numerators
    logic  v4_reg;
    num_t  n4_reg [0:LANES-1];
    norm_t nrm4_reg;
    // stage 5: rounded magnitude
    logic  v5_reg;
    rem_t  m5_reg [0:LANES-1];
    logic  neg5_reg [0:LANES-1];
    norm_t nrm5_reg;
    // divider stages
    logic  dv_reg   [0:DIV_ST-1];
    rem_t  rem_reg  [0:DIV_ST-1][0:LANES-1];
    quo_t  quo_reg  [0:DIV_ST-1][0:LANES-1];
    logic  big_reg  [0:DIV_ST-1][0:LANES-1];
    logic  neg_reg  [0:DIV_ST-1][0:LANES-1];
    norm_t den_reg  [0:DIV_ST-1];
    // output
    logic   ov_reg;
    field_t rot_reg [0:LANES-1];
    logic   zn_reg;
    logic   sat_reg;

    field_t rot_next [0:LANES-1];
    logic   sat_lane [0:LANES-1];
    num_t   n4_next  [0:LANES-1];
    rem_t   mag5     [0:LANES-1];

    assign adv          = !ov_reg || rot_out.ready;
    assign vec_in.ready = adv;

    always_comb
    begin
        n4_next[0] = -num_t'(pq3_reg[0]) + num_t'(pq3_reg[1])
                     - num_t'(pq3_reg[2]) + num_t'(pq3_reg[3]);
        n4_next[1] = -num_t'(pq3_reg[4]) + num_t'(pq3_reg[5])
                     - num_t'(pq3_reg[6]) + num_t'(pq3_reg[7]);
        n4_next[2] = -num_t'(pq3_reg[8]) + num_t'(pq3_reg[9])
                     - num_t'(pq3_reg[10]) + num_t'(pq3_reg[11]);
        for (int l = 0; l < LANES; l++)
        begin
            mag5[l] = n4_reg[l][NUM_W-1] ? rem_t'(-n4_reg[l]) : rem_t'(n4_reg[l]);
        end
    end

    // control: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int s = 0; s < DIV_ST; s++)
            begin
                dv_reg[s] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= vec_in.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int s = 1; s < DIV_ST; s++)
            begin
                dv_reg[s] <= dv_reg[s-1];
            end
            ov_reg <= dv_reg[DIV_ST-1];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            qv1_reg[0]  <= vec_in.quat_x * vec_in.vec_x;
            qv1_reg[1]  <= vec_in.quat_y * vec_in.vec_y;
            qv1_reg[2]  <= vec_in.quat_z * vec_in.vec_z;
            qv1_reg[3]  <= vec_in.quat_w * vec_in.vec_x;
            qv1_reg[4]  <= vec_in.quat_y * vec_in.vec_z;
            qv1_reg[5]  <= vec_in.quat_z * vec_in.vec_y;
            qv1_reg[6]  <= vec_in.quat_w * vec_in.vec_y;
            qv1_reg[7]  <= vec_in.quat_x * vec_in.vec_z;
            qv1_reg[8]  <= vec_in.quat_z * vec_in.vec_x;
            qv1_reg[9]  <= vec_in.quat_w * vec_in.vec_z;
            qv1_reg[10] <= vec_in.quat_x * vec_in.vec_y;
            qv1_reg[11] <= vec_in.quat_y * vec_in.vec_x;
            sq1_reg[0] <= vec_in.quat_w * vec_in.quat_w;
            sq1_reg[1] <= vec_in.quat_x * vec_in.quat_x;
            sq1_reg[2] <= vec_in.quat_y * vec_in.quat_y;
            sq1_reg[3] <= vec_in.quat_z * vec_in.quat_z;
            q1_reg[0]  <= vec_in.quat_w;
            q1_reg[1]  <= vec_in.quat_x;
            q1_reg[2]  <= vec_in.quat_y;
            q1_reg[3]  <= vec_in.quat_z;
            // stage 2
            p2_reg[0] <= -p_t'(qv1_reg[0]) - p_t'(qv1_reg[1]) - p_t'(qv1_reg[2]);
            p2_reg[1] <= p_t'(qv1_reg[3]) + p_t'(qv1_reg[4]) - p_t'(qv1_reg[5]);
            p2_reg[2] <= p_t'(qv1_reg[6]) - p_t'(qv1_reg[7]) + p_t'(qv1_reg[8]);
            p2_reg[3] <= p_t'(qv1_reg[9]) + p_t'(qv1_reg[10]) - p_t'(qv1_reg[11]);
            nrm2_reg  <= norm_t'(sq1_reg[0]) + norm_t'(sq1_reg[1])
                         + norm_t'(sq1_reg[2]) + norm_t'(sq1_reg[3]);
            q2_reg    <= q1_reg;
            // stage 3: nx = -pw*qx + px*qw - py*qz + pz*qy, etc.
            pq3_reg[0]  <= p2_reg[0] * q2_reg[1];
            pq3_reg[1]  <= p2_reg[1] * q2_reg[0];
            pq3_reg[2]  <= p2_reg[2] * q2_reg[3];
            pq3_reg[3]  <= p2_reg[3] * q2_reg[2];
            pq3_reg[4]  <= p2_reg[0] * q2_reg[2];
            pq3_reg[5]  <= p2_reg[2] * q2_reg[0];
            pq3_reg[6]  <= p2_reg[3] * q2_reg[1];
            pq3_reg[7]  <= p2_reg[1] * q2_reg[3];
            pq3_reg[8]  <= p2_reg[0] * q2_reg[3];
            pq3_reg[9]  <= p2_reg[3] * q2_reg[0];
            pq3_reg[10] <= p2_reg[1] * q2_reg[2];
            pq3_reg[11] <= p2_reg[2] * q2_reg[1];
            nrm3_reg    <= nrm2_reg;
            // stage 4
            n4_reg   <= n4_next;
            nrm4_reg <= nrm3_reg;
            // stage 5: add half the divisor for round to nearest
            for (int l = 0; l < LANES; l++)
            begin
                m5_reg[l]   <= mag5[l] + rem_t'(nrm4_reg >> 1);
                neg5_reg[l] <= n4_reg[l][NUM_W-1];
            end
            nrm5_reg <= nrm4_reg;
            // divider range check: quotient of 2^16 or more always clamps
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= m5_reg[l];
                quo_reg[0][l] <= '0;
                big_reg[0][l] <= m5_reg[l] >= (rem_t'(nrm5_reg) << QUO_W);
                neg_reg[0][l] <= neg5_reg[l];
            end
            den_reg[0] <= nrm5_reg;
            // one quotient bit per stage
            for (int s = 1; s < DIV_ST; s++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (rem_reg[s-1][l] >= (rem_t'(den_reg[s-1]) << (QUO_W - s)))
                    begin
                        rem_reg[s][l] <= rem_reg[s-1][l]
                                         - (rem_t'(den_reg[s-1]) << (QUO_W - s));
                        quo_reg[s][l] <= quo_reg[s-1][l] | (quo_t'(1) << (QUO_W - s));
                    end
                    else
                    begin
                        rem_reg[s][l] <= rem_reg[s-1][l];
                        quo_reg[s][l] <= quo_reg[s-1][l];
                    end
                    big_reg[s][l] <= big_reg[s-1][l];
                    neg_reg[s][l] <= neg_reg[s-1][l];
                end
                den_reg[s] <= den_reg[s-1];
            end
            // output
            rot_reg <= rot_next;
            zn_reg  <= (den_reg[DIV_ST-1] == '0);
            sat_reg <= (den_reg[DIV_ST-1] != '0)
                       && (sat_lane[0] || sat_lane[1] || sat_lane[2]);
        end
    end

    // final clamp
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic big;
            logic neg;
            quo_t q;
            big = big_reg[DIV_ST-1][l];
            neg = neg_reg[DIV_ST-1][l];
            q   = quo_reg[DIV_ST-1][l];
            if (neg)
            begin
                sat_lane[l] = big || (q > quo_t'(16'h8000));
                rot_next[l] = sat_lane[l] ? SAT_MIN : field_t'(-q);
            end
            else
            begin
                sat_lane[l] = big || q[QUO_W-1];
                rot_next[l] = sat_lane[l] ? SAT_MAX : field_t'(q);
            end
            if (den_reg[DIV_ST-1] == '0)
            begin
                rot_next[l] = '0;
            end
        end
    end

    assign rot_out.valid     = ov_reg;
    assign rot_out.rot_x     = rot_reg[0];
    assign rot_out.rot_y     = rot_reg[1];
    assign rot_out.rot_z     = rot_reg[2];
    assign rot_out.zero_norm = zn_reg;
    assign rot_out.saturated = sat_reg;

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && zn_reg |-> !sat_reg && rot_reg[0] == '0 && rot_reg[1] == '0
                             && rot_reg[2] == '0)
        else $error("zero norm beat carries nonzero result");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && sat_reg |-> rot_reg[0] == SAT_MAX || rot_reg[0] == SAT_MIN
                              || rot_reg[1] == SAT_MAX || rot_reg[1] == SAT_MIN
                              || rot_reg[2] == SAT_MAX || rot_reg[2] == SAT_MIN)
        else $error("saturated flag without a clamped component");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v5_reg) && $stable(dv_reg[0]) && $stable(ov_reg))
        else $error("pipeline moved during a stall");

endmodule
